>>> hdl/assert_macros.svh
// Assertion macros used by the cache engine datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset
`define CHK_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define CHK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/scc_pkg.sv
// Shared types and codes of the sector cache clock replacement engine.
package scc_pkg;

    // Command codes
    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_FLUSH = 2'd2;
    localparam logic [1:0] CMD_CLEAR = 2'd3;

    // Result action codes
    localparam logic [1:0] ACT_WRITEBACK = 2'd0;
    localparam logic [1:0] ACT_DONE      = 2'd1;
    localparam logic [1:0] ACT_MAINT     = 2'd2;

    localparam int SLOT_FIELD_BITS   = 6;
    localparam int SECTOR_FIELD_BITS = 32;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOOK_RD,
        ST_LOOK_CMP,
        ST_HIT,
        ST_MISS,
        ST_SWEEP,
        ST_VICT,
        ST_FILL,
        ST_MAINT,
        ST_WB_SCAN,
        ST_WB_EMIT
    } scc_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;          // latch command and sector, rewind scan index
        logic scan_inc;
        logic tag_rd_scan;   // read tag at scan index
        logic tag_rd_hand;   // read tag at clock hand
        logic hand_adv;
        logic ref_clr_hand;
        logic emit_hit;
        logic emit_vict_wb;
        logic fill;
        logic emit_wb;
        logic emit_none;
        logic clear_all;
    } scc_ctrl_t;

    // Status from datapath to controller
    typedef struct packed {
        logic out_busy;
        logic match;
        logic idx_last;
        logic hand_victim;
        logic vict_dirty;
        logic any_vd;
        logic idx_vd;
        logic wb_last;
        logic is_clear;
    } scc_stat_t;

endpackage

>>> hdl/scc_ctrl.sv
// Controller state machine of the sector cache engine.
module scc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [1:0]          cmd,
    output logic                in_ready,
    input  scc_pkg::scc_stat_t  stat,
    output scc_pkg::scc_ctrl_t  ctl
);

    scc_pkg::scc_state_t state_reg, state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= scc_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            scc_pkg::ST_IDLE:
                if (in_valid)
                begin
                    if (cmd == scc_pkg::CMD_READ || cmd == scc_pkg::CMD_WRITE)
                        state_next = scc_pkg::ST_LOOK_RD;
                    else
                        state_next = scc_pkg::ST_MAINT;
                end
            scc_pkg::ST_LOOK_RD:
                state_next = scc_pkg::ST_LOOK_CMP;
            scc_pkg::ST_LOOK_CMP:
                if (stat.match)
                    state_next = scc_pkg::ST_HIT;
                else if (stat.idx_last)
                    state_next = scc_pkg::ST_MISS;
                else
                    state_next = scc_pkg::ST_LOOK_RD;
            scc_pkg::ST_HIT:
                if (!stat.out_busy)
                    state_next = scc_pkg::ST_IDLE;
            scc_pkg::ST_MISS:
                state_next = scc_pkg::ST_SWEEP;
            scc_pkg::ST_SWEEP:
                if (stat.hand_victim)
                    state_next = scc_pkg::ST_VICT;
            scc_pkg::ST_VICT:
                if (!stat.vict_dirty || !stat.out_busy)
                    state_next = scc_pkg::ST_FILL;
            scc_pkg::ST_FILL:
                if (!stat.out_busy)
                    state_next = scc_pkg::ST_IDLE;
            scc_pkg::ST_MAINT:
                if (stat.any_vd)
                    state_next = scc_pkg::ST_WB_SCAN;
                else if (!stat.out_busy)
                    state_next = scc_pkg::ST_IDLE;
            scc_pkg::ST_WB_SCAN:
                if (stat.idx_vd)
                    state_next = scc_pkg::ST_WB_EMIT;
            scc_pkg::ST_WB_EMIT:
                if (!stat.out_busy)
                    state_next = stat.wb_last ? scc_pkg::ST_IDLE : scc_pkg::ST_WB_SCAN;
            default:
                state_next = scc_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        ctl      = '0;
        in_ready = 1'b0;
        case (state_reg)
            scc_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                ctl.load = in_valid;
            end
            scc_pkg::ST_LOOK_RD:
                ctl.tag_rd_scan = 1'b1;
            scc_pkg::ST_LOOK_CMP:
                ctl.scan_inc = !stat.match && !stat.idx_last;
            scc_pkg::ST_HIT:
                ctl.emit_hit = !stat.out_busy;
            scc_pkg::ST_MISS:
                ctl.hand_adv = 1'b1;
            scc_pkg::ST_SWEEP:
            begin
                ctl.tag_rd_hand  = stat.hand_victim;
                ctl.ref_clr_hand = !stat.hand_victim;
                ctl.hand_adv     = !stat.hand_victim;
            end
            scc_pkg::ST_VICT:
                ctl.emit_vict_wb = stat.vict_dirty && !stat.out_busy;
            scc_pkg::ST_FILL:
                ctl.fill = !stat.out_busy;
            scc_pkg::ST_MAINT:
            begin
                ctl.emit_none = !stat.any_vd && !stat.out_busy;
                ctl.clear_all = !stat.any_vd && !stat.out_busy && stat.is_clear;
            end
            scc_pkg::ST_WB_SCAN:
            begin
                ctl.tag_rd_scan = stat.idx_vd;
                ctl.scan_inc    = !stat.idx_vd;
            end
            scc_pkg::ST_WB_EMIT:
            begin
                ctl.emit_wb   = !stat.out_busy;
                ctl.scan_inc  = !stat.out_busy && !stat.wb_last;
                ctl.clear_all = !stat.out_busy && stat.wb_last && stat.is_clear;
            end
            default:
                ctl = '0;
        endcase
    end

endmodule

>>> hdl/scc_dpath.sv
// Datapath: slot state bits, tag memory, scan index, clock hand, result register.
`include "assert_macros.svh"

module scc_dpath #(
    parameter int SLOT_COUNT  = 64,
    parameter int SECTOR_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  scc_pkg::scc_ctrl_t  ctl,
    output scc_pkg::scc_stat_t  stat,
    input  logic [1:0]          cmd,
    input  logic [scc_pkg::SECTOR_FIELD_BITS-1:0] sector,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [1:0]          action,
    output logic [scc_pkg::SLOT_FIELD_BITS-1:0]   slot,
    output logic [scc_pkg::SECTOR_FIELD_BITS-1:0] disk_sector,
    output logic                hit,
    output logic                fetch,
    output logic                last
);

    localparam int IW = $clog2(SLOT_COUNT);
    localparam logic [IW-1:0] IDX_LAST = IW'(SLOT_COUNT - 1);

    logic [SLOT_COUNT-1:0]  valid_reg, dirty_reg, ref_reg;
    logic [IW-1:0]          idx_reg, hand_reg;
    logic [1:0]             cmd_reg;
    logic [SECTOR_BITS-1:0] sec_reg;
    logic [SECTOR_BITS-1:0] tag_mem [SLOT_COUNT];
    logic [SECTOR_BITS-1:0] tag_q;
    logic [IW-1:0]          hand_inc;
    logic [SLOT_COUNT-1:0]  vd, vd_others;
    logic                   is_write;

    logic                   out_valid_reg;
    logic [1:0]             action_reg;
    logic [scc_pkg::SLOT_FIELD_BITS-1:0]   slot_reg;
    logic [scc_pkg::SECTOR_FIELD_BITS-1:0] disk_reg;
    logic                   hit_reg, fetch_reg, last_reg;

    assign is_write = (cmd_reg == scc_pkg::CMD_WRITE);
    assign hand_inc = (hand_reg == IDX_LAST) ? '0 : hand_reg + 1'b1;
    assign vd       = valid_reg & dirty_reg;

    // Dirty slots other than the one under the scan index
    always_comb
    begin
        vd_others          = vd;
        vd_others[idx_reg] = 1'b0;
    end

    // Status back to the controller
    always_comb
    begin
        stat.out_busy    = out_valid_reg && !out_ready;
        stat.match       = valid_reg[idx_reg] && (tag_q == sec_reg);
        stat.idx_last    = (idx_reg == IDX_LAST);
        stat.hand_victim = !valid_reg[hand_reg] || !ref_reg[hand_reg];
        stat.vict_dirty  = vd[hand_reg];
        stat.any_vd      = |vd;
        stat.idx_vd      = vd[idx_reg];
        stat.wb_last     = !(|vd_others);
        stat.is_clear    = (cmd_reg == scc_pkg::CMD_CLEAR);
    end

    // Command and sector latch
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg <= cmd;
            sec_reg <= sector[SECTOR_BITS-1:0];
        end
    end

    // Tag memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (ctl.fill)
            tag_mem[hand_reg] <= sec_reg;
        if (ctl.tag_rd_scan)
            tag_q <= tag_mem[idx_reg];
        else if (ctl.tag_rd_hand)
            tag_q <= tag_mem[hand_reg];
    end

    // Scan index and clock hand
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= '0;
            hand_reg <= IDX_LAST;
        end
        else
        begin
            if (ctl.load)
                idx_reg <= '0;
            else if (ctl.scan_inc)
                idx_reg <= idx_reg + 1'b1;
            if (ctl.clear_all)
                hand_reg <= '0;
            else if (ctl.hand_adv)
                hand_reg <= hand_inc;
        end
    end

    // Per-slot valid, dirty and reference bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            dirty_reg <= '0;
            ref_reg   <= '0;
        end
        else if (ctl.clear_all)
        begin
            valid_reg <= '0;
            dirty_reg <= '0;
            ref_reg   <= '0;
        end
        else
        begin
            if (ctl.emit_hit)
            begin
                ref_reg[idx_reg] <= 1'b1;
                if (is_write)
                    dirty_reg[idx_reg] <= 1'b1;
            end
            if (ctl.ref_clr_hand)
                ref_reg[hand_reg] <= 1'b0;
            if (ctl.fill)
            begin
                valid_reg[hand_reg] <= 1'b1;
                dirty_reg[hand_reg] <= is_write;
                ref_reg[hand_reg]   <= 1'b1;
            end
            if (ctl.emit_wb)
                dirty_reg[idx_reg] <= 1'b0;
        end
    end

    // Result register valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ctl.emit_hit || ctl.emit_vict_wb || ctl.fill || ctl.emit_wb || ctl.emit_none)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (ctl.emit_hit)
        begin
            action_reg <= scc_pkg::ACT_DONE;
            slot_reg   <= scc_pkg::SLOT_FIELD_BITS'(idx_reg);
            disk_reg   <= scc_pkg::SECTOR_FIELD_BITS'(sec_reg);
            hit_reg    <= 1'b1;
            fetch_reg  <= 1'b0;
            last_reg   <= 1'b1;
        end
        else if (ctl.emit_vict_wb)
        begin
            action_reg <= scc_pkg::ACT_WRITEBACK;
            slot_reg   <= scc_pkg::SLOT_FIELD_BITS'(hand_reg);
            disk_reg   <= scc_pkg::SECTOR_FIELD_BITS'(tag_q);
            hit_reg    <= 1'b0;
            fetch_reg  <= 1'b0;
            last_reg   <= 1'b0;
        end
        else if (ctl.fill)
        begin
            action_reg <= scc_pkg::ACT_DONE;
            slot_reg   <= scc_pkg::SLOT_FIELD_BITS'(hand_reg);
            disk_reg   <= scc_pkg::SECTOR_FIELD_BITS'(sec_reg);
            hit_reg    <= 1'b0;
            fetch_reg  <= !is_write;
            last_reg   <= 1'b1;
        end
        else if (ctl.emit_wb)
        begin
            action_reg <= scc_pkg::ACT_WRITEBACK;
            slot_reg   <= scc_pkg::SLOT_FIELD_BITS'(idx_reg);
            disk_reg   <= scc_pkg::SECTOR_FIELD_BITS'(tag_q);
            hit_reg    <= 1'b0;
            fetch_reg  <= 1'b0;
            last_reg   <= stat.wb_last;
        end
        else if (ctl.emit_none)
        begin
            action_reg <= scc_pkg::ACT_MAINT;
            slot_reg   <= '0;
            disk_reg   <= '0;
            hit_reg    <= 1'b0;
            fetch_reg  <= 1'b0;
            last_reg   <= 1'b1;
        end
    end

    assign out_valid   = out_valid_reg;
    assign action      = action_reg;
    assign slot        = slot_reg;
    assign disk_sector = disk_reg;
    assign hit         = hit_reg;
    assign fetch       = fetch_reg;
    assign last        = last_reg;

    // A hit only reports a slot that holds a sector
    `CHK_SAME(a_hit_valid, ctl.emit_hit, valid_reg[idx_reg], "hit on empty slot")
    // A fill leaves its slot valid and referenced
    `CHK_NEXT(a_fill_bits, ctl.fill, valid_reg[hand_reg] && ref_reg[hand_reg], "fill bits")
    // A write-back during maintenance cleans its slot
    `CHK_NEXT(a_wb_clean, ctl.emit_wb && !ctl.clear_all,
              out_valid_reg && action_reg == scc_pkg::ACT_WRITEBACK && !dirty_reg[$past(idx_reg)],
              "write-back left slot dirty")

endmodule

>>> hdl/sector_cache_clock_replacement_top.sv
// Top level of the sector cache tag and clock replacement engine.
//
//  channel | handshake              | payload
//  --------+------------------------+----------------------------------------------
//  in      | in_valid / in_ready    | cmd, sector
//  out     | out_valid / out_ready  | action, slot, disk_sector, hit, fetch, last
//
// A command is taken only while the engine is idle. Lookup reads each tag in
// LOOK_RD and compares it in LOOK_CMP, from slot 0 up; a miss scans all SLOT_COUNT
// slots, then the clock hand steps one slot per cycle (up to two passes). Flush
// and clear step one slot per cycle past clean slots and stop at each dirty one
// to read its tag and emit a write-back. Reset empties all slots at once; no
// clearing pass. A stalled result register holds the engine at its next result.
module sector_cache_clock_replacement_top #(
    parameter int SLOT_COUNT  = 64,
    parameter int SECTOR_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  cmd,
    input  logic [31:0] sector,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  action,
    output logic [5:0]  slot,
    output logic [31:0] disk_sector,
    output logic        hit,
    output logic        fetch,
    output logic        last
);

    scc_pkg::scc_ctrl_t ctl;
    scc_pkg::scc_stat_t stat;

    scc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .cmd      (cmd),
        .in_ready (in_ready),
        .stat     (stat),
        .ctl      (ctl)
    );

    scc_dpath #(
        .SLOT_COUNT  (SLOT_COUNT),
        .SECTOR_BITS (SECTOR_BITS)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .stat        (stat),
        .cmd         (cmd),
        .sector      (sector),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .action      (action),
        .slot        (slot),
        .disk_sector (disk_sector),
        .hit         (hit),
        .fetch       (fetch),
        .last        (last)
    );

endmodule

>>> dv/testbench.sv
// Self-checking testbench for the sector cache tag and clock replacement engine.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOT = 64;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic [1:0]  action;
        logic [5:0]  slot;
        logic [31:0] disk_sector;
        logic        hit;
        logic        fetch;
        logic        last;
    } cache_result_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  cmd;
    logic [31:0] sector;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  action;
    logic [5:0]  slot;
    logic [31:0] disk_sector;
    logic        hit;
    logic        fetch;
    logic        last;

    sector_cache_clock_replacement_top dut (.*);

    // Shadow copy of the cache state
    logic        shadow_valid [NSLOT];
    logic        shadow_dirty [NSLOT];
    logic        shadow_ref   [NSLOT];
    logic [31:0] shadow_tag   [NSLOT];
    logic [5:0]  shadow_hand;

    cache_result_t expected_results[$];
    int  error_count = 0;
    int  result_count = 0;
    int  item_count = 0;
    int  cycle_count = 0;
    bit  hold_off = 0;
    bit  random_stalls = 1;
    logic [31:0] recent_sectors[$];

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    // Cycle limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic cache_result_t mk(logic [1:0] a, logic [5:0] s, logic [31:0] d,
                                         logic h, logic f, logic l);
        cache_result_t r;
        r.action = a; r.slot = s; r.disk_sector = d; r.hit = h; r.fetch = f; r.last = l;
        return r;
    endfunction

    task automatic shadow_reset();
        for (int i = 0; i < NSLOT; i++)
        begin
            shadow_valid[i] = 0; shadow_dirty[i] = 0; shadow_ref[i] = 0; shadow_tag[i] = 0;
        end
        shadow_hand = 6'(NSLOT - 1);
    endtask

    // Flush or clear: write back dirty slots in index order
    task automatic predict_writeback_all(bit empty_after);
        int n;
        n = 0;
        for (int i = 0; i < NSLOT; i++)
        begin
            if (shadow_valid[i] && shadow_dirty[i])
            begin
                expected_results.push_back(mk(scc_pkg::ACT_WRITEBACK, 6'(i), shadow_tag[i],
                                              1'b0, 1'b0, 1'b0));
                n++;
            end
            shadow_dirty[i] = 0;
            if (empty_after)
            begin
                shadow_valid[i] = 0; shadow_ref[i] = 0; shadow_tag[i] = 0;
            end
        end
        if (n == 0)
            expected_results.push_back(mk(scc_pkg::ACT_MAINT, 6'd0, 32'h0, 1'b0, 1'b0, 1'b1));
        else
            expected_results[$].last = 1;
        if (empty_after)
            shadow_hand = 6'd0;
    endtask

    task automatic predict_cache_command(logic [1:0] c, logic [31:0] s);
        logic [5:0] v;
        if (c == scc_pkg::CMD_FLUSH) begin predict_writeback_all(0); return; end
        if (c == scc_pkg::CMD_CLEAR) begin predict_writeback_all(1); return; end
        for (int i = 0; i < NSLOT; i++)
        begin
            if (shadow_valid[i] && shadow_tag[i] == s)
            begin
                shadow_ref[i] = 1;
                if (c == scc_pkg::CMD_WRITE)
                    shadow_dirty[i] = 1;
                expected_results.push_back(mk(scc_pkg::ACT_DONE, 6'(i), s, 1'b1, 1'b0, 1'b1));
                return;
            end
        end
        // Clock sweep for a victim
        shadow_hand = shadow_hand + 6'd1;
        while (shadow_valid[shadow_hand] && shadow_ref[shadow_hand])
        begin
            shadow_ref[shadow_hand] = 0;
            shadow_hand = shadow_hand + 6'd1;
        end
        v = shadow_hand;
        if (shadow_valid[v] && shadow_dirty[v])
            expected_results.push_back(mk(scc_pkg::ACT_WRITEBACK, v, shadow_tag[v],
                                          1'b0, 1'b0, 1'b0));
        shadow_valid[v] = 1;
        shadow_dirty[v] = (c == scc_pkg::CMD_WRITE);
        shadow_ref[v] = 1;
        shadow_tag[v] = s;
        expected_results.push_back(mk(scc_pkg::ACT_DONE, v, s, 1'b0,
                                      c != scc_pkg::CMD_WRITE, 1'b1));
    endtask

    // Send one command and predict its results at transfer
    task automatic send_command(logic [1:0] c, logic [31:0] s);
        int gap;
        gap = random_stalls ? $urandom_range(0, 5) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 0;
            cmd <= 2'($urandom);
            sector <= $urandom;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1;
        cmd <= c;
        sector <= s;
        do @(posedge clk); while (!in_ready);
        predict_cache_command(c, s);
        item_count++;
        recent_sectors.push_back(s);
        if (recent_sectors.size() > 40)
            void'(recent_sectors.pop_front());
    endtask

    // Receiver: a drawn wait before each result, or a long hold-off
    initial
    begin
        int wait_cycles;
        out_ready = 0;
        forever
        begin
            @(negedge clk);
            if (hold_off)
                out_ready <= 0;
            else
            begin
                wait_cycles = random_stalls ? $urandom_range(0, 5) : 0;
                if (wait_cycles > 0)
                begin
                    out_ready <= 0;
                    repeat (wait_cycles) @(negedge clk);
                end
                out_ready <= 1;
                do @(posedge clk); while (!out_valid && !hold_off);
            end
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        cache_result_t got, exp_r;
        if (rst_n && out_valid && out_ready)
        begin
            got = mk(action, slot, disk_sector, hit, fetch, last);
            result_count++;
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result %p", $time, got);
                error_count++;
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (got.action !== exp_r.action)
                    $display("%0t: action expected %0d actual %0d", $time, exp_r.action, got.action);
                if (got.slot !== exp_r.slot)
                    $display("%0t: slot expected %0d actual %0d", $time, exp_r.slot, got.slot);
                if (got.disk_sector !== exp_r.disk_sector)
                    $display("%0t: disk_sector expected %h actual %h", $time,
                             exp_r.disk_sector, got.disk_sector);
                if (got.hit !== exp_r.hit)
                    $display("%0t: hit expected %0d actual %0d", $time, exp_r.hit, got.hit);
                if (got.fetch !== exp_r.fetch)
                    $display("%0t: fetch expected %0d actual %0d", $time, exp_r.fetch, got.fetch);
                if (got.last !== exp_r.last)
                    $display("%0t: last expected %0d actual %0d", $time, exp_r.last, got.last);
                if (got !== exp_r)
                    error_count++;
            end
        end
    end

    function automatic logic [31:0] pick_sector();
        int k;
        k = $urandom_range(0, 9);
        if (k < 5 && recent_sectors.size() > 0)
            return recent_sectors[$urandom_range(0, recent_sectors.size() - 1)];
        if (k < 8)
            return $urandom_range(0, 95);
        return $urandom;
    endfunction

    // Drop the input and wait for all predicted results
    task automatic drain();
        @(negedge clk);
        in_valid <= 0;
        cmd <= 2'($urandom);
        sector <= $urandom;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    // Directed: extremes, hits, misses, flush and clear on empty and dirty caches
    task automatic test_directed();
        send_command(scc_pkg::CMD_FLUSH, 32'h0);
        send_command(scc_pkg::CMD_CLEAR, 32'hFFFF_FFFF);
        send_command(scc_pkg::CMD_READ, 32'h0);
        send_command(scc_pkg::CMD_READ, 32'hFFFF_FFFF);
        send_command(scc_pkg::CMD_WRITE, 32'hFFFF_FFFF);
        send_command(scc_pkg::CMD_WRITE, 32'hAAAA_5555);
        send_command(scc_pkg::CMD_READ, 32'h0);
        send_command(scc_pkg::CMD_WRITE, 32'h5555_AAAA);
        send_command(scc_pkg::CMD_FLUSH, 32'h1234);
        send_command(scc_pkg::CMD_FLUSH, 32'h0);
        send_command(scc_pkg::CMD_WRITE, 32'h1);
        send_command(scc_pkg::CMD_CLEAR, 32'h0);
        send_command(scc_pkg::CMD_CLEAR, 32'h0);
        send_command(scc_pkg::CMD_READ, 32'h7);
        drain();
    endtask

    // Fill all slots dirty, then force sweeps with victim write-backs
    task automatic test_full_sweep();
        for (int i = 0; i < NSLOT; i++)
            send_command(scc_pkg::CMD_WRITE, 32'h1000 + i);
        send_command(scc_pkg::CMD_READ, 32'h1005);
        for (int i = 0; i < 8; i++)
            send_command(2'($urandom_range(0, 1)), 32'h2000 + i);
        send_command(scc_pkg::CMD_FLUSH, 32'h0);
        drain();
    endtask

    // Receiver holds off while sender keeps offering commands
    task automatic test_backpressure();
        hold_off = 1;
        fork
            begin
                repeat (400) @(posedge clk);
                hold_off = 0;
            end
            for (int i = 0; i < 10; i++)
                send_command(scc_pkg::CMD_WRITE, 32'h3000 + i);
        join
        drain();
    endtask

    task automatic test_random();
        int k;
        for (int i = 0; i < 232; i++)
        begin
            if (i == 110)
                random_stalls = 0;
            if (i == 150)
                random_stalls = 1;
            k = $urandom_range(0, 19);
            if (k < 18)
                send_command(2'($urandom_range(0, 1)), pick_sector());
            else
                send_command(k == 18 ? scc_pkg::CMD_FLUSH : scc_pkg::CMD_CLEAR, $urandom);
        end
        drain();
    endtask

    initial
    begin
        rst_n = 0;
        in_valid = 0;
        cmd = 0;
        sector = 0;
        shadow_reset();
        repeat (9) @(negedge clk);
        rst_n = 1;
        @(negedge clk);
        test_directed();
        test_full_sweep();
        test_backpressure();
        test_random();
        $display("Covered %0d commands and %0d results: hits, clock sweeps, write-backs,",
                 item_count, result_count);
        $display("flush and clear, with random stalls and a long receiver hold-off.");
        if (error_count == 0 && expected_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
